### src/mks_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// shared types and constants for the 4x4 keypad scanner
// no dependencies

package mks_pkg;

    localparam int unsigned ROWS        = 4;
    localparam int unsigned COLS        = 4;
    localparam int unsigned LIMIT_BITS  = 16;
    localparam int unsigned CODE_BITS   = 7;
    localparam int unsigned CFG_IDX_BITS = 2;

    localparam logic [LIMIT_BITS-1:0] DEBOUNCE_RESET = 16'd30;
    localparam logic [LIMIT_BITS-1:0] SETTLE_RESET   = 16'd20;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SETTLE   = 2'd1;

    localparam logic [ROWS-1:0] ROWS_ALL_HIGH = 4'hF;
    localparam logic [ROWS-1:0] ROWS_FIRST_LOW = 4'hE;

    typedef struct packed {
        logic [ROWS-1:0]      row_drive;
        logic                 key_valid;
        logic [CODE_BITS-1:0] key_code;
    } t_result;

    // ascii code of the key at column col, row row
    function automatic logic [CODE_BITS-1:0] key_ascii(input logic [1:0] col,
                                                        input logic [1:0] row);
        logic [CODE_BITS-1:0] code;
        case ({col, row})
            4'h0:    code = 7'h31; // '1'
            4'h1:    code = 7'h34; // '4'
            4'h2:    code = 7'h37; // '7'
            4'h3:    code = 7'h2A; // '*'
            4'h4:    code = 7'h32; // '2'
            4'h5:    code = 7'h35; // '5'
            4'h6:    code = 7'h38; // '8'
            4'h7:    code = 7'h30; // '0'
            4'h8:    code = 7'h33; // '3'
            4'h9:    code = 7'h36; // '6'
            4'hA:    code = 7'h39; // '9'
            4'hB:    code = 7'h23; // '#'
            4'hC:    code = 7'h41; // 'A'
            4'hD:    code = 7'h42; // 'B'
            4'hE:    code = 7'h43; // 'C'
            4'hF:    code = 7'h44; // 'D'
            default: code = '0;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

### src/mks_fsm.sv
`timescale 1ns / 1ps
`default_nettype none
// scan state machine: one tick per advance, result computed in the same cycle
// depends on mks_pkg

module mks_fsm #(
    parameter int unsigned COUNT_BITS = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_advance,
    input  wire logic [mks_pkg::COLS-1:0]        i_column_levels,
    input  wire logic [mks_pkg::LIMIT_BITS-1:0]  i_debounce_ticks,
    input  wire logic [mks_pkg::LIMIT_BITS-1:0]  i_settle_ticks,
    output mks_pkg::t_result                     o_result
);

    localparam int unsigned CMP_BITS =
        (COUNT_BITS > mks_pkg::LIMIT_BITS) ? COUNT_BITS : mks_pkg::LIMIT_BITS;
    localparam logic [CMP_BITS-1:0] CNT_MAX = CMP_BITS'((64'd1 << COUNT_BITS) - 64'd1);

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_DEBOUNCE = 3'd1,
        PH_SETTLE   = 3'd2,
        PH_SCAN     = 3'd3,
        PH_RELEASE  = 3'd4
    } t_phase;

    t_phase                   r_phase, n_phase;
    logic [1:0]               r_column, n_column;
    logic [1:0]               r_row_step, n_row_step;
    logic [COUNT_BITS-1:0]    r_wait, n_wait;
    logic [mks_pkg::ROWS-1:0] r_rows, n_rows;

    logic                     col_high;
    logic [CMP_BITS-1:0]      wait_ext;
    logic [CMP_BITS-1:0]      deb_lim;
    logic [CMP_BITS-1:0]      set_lim;
    logic [COUNT_BITS-1:0]    wait_inc;
    logic [1:0]               step_inc;
    logic [1:0]               first_col;
    logic                     key_valid;
    logic [mks_pkg::CODE_BITS-1:0] key_code;

    always_comb begin
        deb_lim = CMP_BITS'(i_debounce_ticks);
        set_lim = CMP_BITS'(i_settle_ticks);
        if (deb_lim > CNT_MAX) begin
            deb_lim = CNT_MAX;
        end
        if (set_lim > CNT_MAX) begin
            set_lim = CNT_MAX;
        end
    end

    assign col_high = i_column_levels[r_column];
    assign wait_ext = CMP_BITS'(r_wait);
    // saturating count
    assign wait_inc = (r_wait == {COUNT_BITS{1'b1}}) ? r_wait : r_wait + 1'b1;
    assign step_inc = r_row_step + 2'd1;

    // lowest high column wins
    always_comb begin
        if (i_column_levels[0]) begin
            first_col = 2'd0;
        end else if (i_column_levels[1]) begin
            first_col = 2'd1;
        end else if (i_column_levels[2]) begin
            first_col = 2'd2;
        end else begin
            first_col = 2'd3;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_column   = r_column;
        n_row_step = r_row_step;
        n_wait     = r_wait;
        n_rows     = r_rows;
        key_valid  = 1'b0;
        key_code   = '0;
        case (r_phase)
            PH_DEBOUNCE: begin
                if (!col_high) begin
                    n_phase = PH_IDLE;
                end else if (wait_ext >= deb_lim) begin
                    n_phase = PH_SETTLE;
                    n_wait  = '0;
                end else begin
                    n_wait = wait_inc;
                end
            end
            PH_SETTLE: begin
                if (wait_ext >= set_lim) begin
                    n_phase    = PH_SCAN;
                    n_row_step = 2'd0;
                    n_rows     = mks_pkg::ROWS_FIRST_LOW;
                end else begin
                    n_wait = wait_inc;
                end
            end
            PH_SCAN: begin
                if (!col_high) begin
                    key_valid = 1'b1;
                    key_code  = mks_pkg::key_ascii(r_column, r_row_step);
                    n_rows    = mks_pkg::ROWS_ALL_HIGH;
                    n_phase   = PH_RELEASE;
                end else if (r_row_step == 2'd3) begin
                    // no key found with all rows low
                    n_rows  = mks_pkg::ROWS_ALL_HIGH;
                    n_phase = PH_RELEASE;
                end else begin
                    n_row_step = step_inc;
                    n_rows     = r_rows & ~(mks_pkg::ROWS'(1) << step_inc);
                end
            end
            PH_RELEASE: begin
                n_rows = mks_pkg::ROWS_ALL_HIGH;
                if (!col_high) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_rows  = mks_pkg::ROWS_ALL_HIGH;
                n_phase = PH_IDLE;
                if (i_column_levels != '0) begin
                    n_column = first_col;
                    n_wait   = '0;
                    n_phase  = PH_DEBOUNCE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_column   <= 2'd0;
            r_row_step <= 2'd0;
            r_wait     <= '0;
            r_rows     <= mks_pkg::ROWS_ALL_HIGH;
        end else if (i_advance) begin
            r_phase    <= n_phase;
            r_column   <= n_column;
            r_row_step <= n_row_step;
            r_wait     <= n_wait;
            r_rows     <= n_rows;
        end
    end

    assign o_result.row_drive = n_rows;
    assign o_result.key_valid = key_valid;
    assign o_result.key_code  = key_code;

endmodule

`default_nettype wire

### src/matrix_keypad_scanner.sv
`timescale 1ns / 1ps
`default_nettype none
// 4x4 matrix keypad scanner
// one transaction in per tick carries the sampled column levels; one transaction
// out per tick carries the row drive, a key-valid flag and the ascii key code.
// depends on mks_pkg and mks_fsm
//
// the scan state updates in the cycle a tick is accepted and the result lands
// in the output register, or in the skid register while the receiver stalls.
// throughput is one tick per cycle while o_stall is low.
// a skid register holds one extra result while the receiver stalls; o_stall
// rises only once both are full, and no result is dropped or repeated.
// the config port is always ready; write debounce and settle limits only while
// idle. synchronous active-low reset returns to idle with rows high, limits at
// 30 and 20 ticks, and both output registers empty.

module matrix_keypad_scanner #(
    parameter int unsigned COUNT_BITS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output      logic                                o_stall,
    input  wire logic [mks_pkg::COLS-1:0]            i_column_levels,
    output      logic                                o_valid,
    input  wire logic                                i_stall,
    output      logic [mks_pkg::ROWS-1:0]            o_row_drive,
    output      logic                                o_key_valid,
    output      logic [mks_pkg::CODE_BITS-1:0]       o_key_code,
    input  wire logic                                i_cfg_valid,
    output      logic                                o_cfg_ready,
    input  wire logic [mks_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  wire logic [mks_pkg::LIMIT_BITS-1:0]      i_cfg_data
);

    logic [mks_pkg::LIMIT_BITS-1:0] r_debounce;
    logic [mks_pkg::LIMIT_BITS-1:0] r_settle;
    logic                           r_out_valid;
    logic                           r_skid_valid;
    mks_pkg::t_result               r_out;
    mks_pkg::t_result               r_skid;
    mks_pkg::t_result               result;
    logic                           in_accept;
    logic                           out_free;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= mks_pkg::DEBOUNCE_RESET;
            r_settle   <= mks_pkg::SETTLE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mks_pkg::REG_DEBOUNCE: r_debounce <= i_cfg_data;
                mks_pkg::REG_SETTLE:   r_settle   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_stall   = r_skid_valid;
    assign in_accept = i_valid & ~r_skid_valid;
    // output register empties this cycle or already is
    assign out_free  = ~r_out_valid | ~i_stall;

    mks_fsm #(
        .COUNT_BITS (COUNT_BITS)
    ) u_fsm (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_advance        (in_accept),
        .i_column_levels  (i_column_levels),
        .i_debounce_ticks (r_debounce),
        .i_settle_ticks   (r_settle),
        .o_result         (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_accept;
            end
        end else if (in_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : result;
        end else if (in_accept) begin
            r_skid <= result;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_row_drive = r_out.row_drive;
    assign o_key_valid = r_out.key_valid;
    assign o_key_code  = r_out.key_code;

endmodule

`default_nettype wire
